@@ rtl/core/atc_pkg.sv @@
// Shared constants and codes for the autocorrelation tempo estimator.
// Used by atc_store, atc_front and the top level under rtl/core; depends on nothing.
package atc_pkg;

    // field and internal widths
    localparam int SR_W     = 18;   // sample rate register
    localparam int BPM_W    = 10;   // tempo limits
    localparam int STEP_W   = 11;   // decimation step, up to 1310
    localparam int SAMP_W   = 16;   // audio sample
    localparam int VAL_W    = 17;   // envelope value, 0..65536
    localparam int LAG_W    = 14;   // correlation lag, up to 12000
    localparam int TEMPO_W  = 22;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 32;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int ACC_W    = 64;

    // envelope rate is 200 points per second
    localparam int unsigned BPM_SCALE  = 12000;          // 60 * 200
    localparam int unsigned TEMPO_NUM  = 12000 * 256;    // Q8 numerator
    localparam int unsigned MIN_FRAMES_PER_STEP = 400;
    localparam int unsigned MIN_POINTS = 200;

    // smoother coefficients, Q16
    localparam int unsigned COEF_KEEP = 55706;
    localparam int unsigned COEF_NEW  = 9830;
    localparam int unsigned ROUND_HALF = 32768;

    // step = sample_rate / 200 = (sample_rate >> 3) * 41944 >> 20
    localparam int unsigned STEP_RECIP = 41944;
    localparam int STEP_SHIFT = 20;

    // reset values of the configuration
    localparam logic [STEP_W-1:0] STEP_RESET    = 11'd240;
    localparam logic [BPM_W-1:0]  MIN_BPM_RESET = 10'd60;
    localparam logic [BPM_W-1:0]  MAX_BPM_RESET = 10'd200;

    // configuration register indexes
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] REG_MIN_BPM     = 2'd1;
    localparam logic [1:0] REG_MAX_BPM     = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LONG_LAG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WEAK_PEAK = 3'd4;

endpackage

@@ rtl/core/atc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module atc_div #(
    parameter int NW = 31,
    parameter int DW = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quot,
    output logic          done
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    q_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             ge;

    // shift the next numerator bit into the partial remainder
    assign trial = {rem_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/atc_store.sv @@
// Envelope memory: one write port, two registered read ports.
// Uses atc_pkg for the value width.
module atc_store
    import atc_pkg::*;
#(
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [VAL_W-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [VAL_W-1:0]         rdata_a,
    output logic [VAL_W-1:0]         rdata_b
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_a_reg;
    logic [VAL_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/core/atc_front.sv @@
// Front end: decimation, level detect, one-pole smoother, envelope write.
// Uses atc_pkg; feeds atc_store and the analysis sequencer.
module atc_front
    import atc_pkg::*;
#(
    parameter int DEPTH = 8192
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [SAMP_W-1:0]   left_sample,
    input  logic signed [SAMP_W-1:0]   right_sample,
    input  logic [STEP_W-1:0]          step,
    input  logic                       clr,
    output logic                       busy,
    output logic [FRAME_W-1:0]         frames,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [$clog2(DEPTH+1)+15:0] sum,
    output logic                       we,
    output logic [$clog2(DEPTH)-1:0]   waddr,
    output logic [VAL_W-1:0]           wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = CW + 16;

    logic [FRAME_W-1:0] frames_reg;
    logic [STEP_W-1:0]  phase_reg;
    logic               a_valid_reg;
    logic [VAL_W-1:0]   x_reg;
    logic [31:0]        kx_reg;
    logic [VAL_W-1:0]   s_reg;
    logic [CW-1:0]      count_reg;
    logic [SW-1:0]      sum_reg;

    logic [VAL_W-1:0]   x;
    logic [VAL_W-1:0]   s_src;
    logic [33:0]        s_full;
    logic [VAL_W-1:0]   s_new;
    logic [STEP_W:0]    phase_inc;
    logic               room;

    // level of the mean of both channels, doubled: |l + r|
    always_comb
    begin
        logic signed [VAL_W-1:0] lr;
        lr = VAL_W'(left_sample) + VAL_W'(right_sample);
        x  = lr[VAL_W-1] ? VAL_W'(-lr) : VAL_W'(lr);
    end

    assign phase_inc = {1'b0, phase_reg} + 1'b1;

    // frame count and decimation phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg  <= '0;
            phase_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else if (clr)
        begin
            frames_reg  <= '0;
            phase_reg   <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept && (phase_reg == '0);
            if (accept)
            begin
                if (frames_reg != '1)
                begin
                    frames_reg <= frames_reg + 1'b1;
                end
                phase_reg <= (phase_inc >= {1'b0, step}) ? '0 : phase_inc[STEP_W-1:0];
            end
        end
    end

    // new-sample term of the smoother, rounding constant folded in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= x;
            kx_reg <= 32'(x * 32'(COEF_NEW)) + 32'(ROUND_HALF);
        end
    end

    // recurrence: s = (s*keep + x*new + half) >> 16, first point loads s = x
    assign s_src  = (count_reg == '0) ? x_reg : s_reg;
    assign s_full = 34'(s_src * 34'(COEF_KEEP)) + 34'(kx_reg);
    assign s_new  = s_full[16 +: VAL_W];
    assign room   = count_reg < CW'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg     <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (clr)
        begin
            s_reg     <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (a_valid_reg)
        begin
            s_reg <= s_new;
            if (room)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SW'(s_new);
            end
        end
    end

    assign busy   = a_valid_reg;
    assign frames = frames_reg;
    assign count  = count_reg;
    assign sum    = sum_reg;
    assign we     = a_valid_reg && room;
    assign waddr  = count_reg[AW-1:0];
    assign wdata  = s_new;

endmodule

@@ rtl/core/autocorrelation_tempo_estimator.sv @@
// Top level of the autocorrelation tempo estimator.
// Uses atc_pkg, atc_front, atc_store and atc_div.
//
// Usage:
//   s_axis carries one stereo frame per beat: tdata = {right, left}, tlast
//   marks the last frame of a clip. Frames are taken one per cycle while
//   the block is loading. On the last frame s_axis_tready drops and the
//   analysis runs; m_axis then carries one beat {status, tempo_q8}.
//   Configuration (sample rate, min and max bpm) must be written by the user through
//   cfg_we / cfg_index / cfg_data while the block is idle; the block does not enforce it.
// Analysis after the last frame runs the divider (NW bits, NW = max(clog2(depth+1)+17, 22),
// 31 at the default depth) for the high lag, the low lag and the mean, then the lag
// loop, then the divider for the tempo. The lag loop is set by the two read ports
// of the envelope memory: one product per cycle within a lag, with the pipeline drained
// between lags. A failed range or length check answers without the divider or lag loop.
// Reset clears all clip state and loads the default configuration; the
// envelope memory is not cleared, only entries written in the current
// clip are read. A stalled m_axis holds its beat; loading of the next
// clip goes on, and the next result waits until the held beat is taken.
module autocorrelation_tempo_estimator
    import atc_pkg::*;
#(
    parameter int ENVELOPE_DEPTH = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [SR_W-1:0]   cfg_data,
    // frames in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic              s_axis_tlast,   // last_frame
    // result out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // [21:0] tempo_q8, [24:22] status, zero pad
);

    localparam int AW = $clog2(ENVELOPE_DEPTH);
    localparam int CW = $clog2(ENVELOPE_DEPTH + 1);
    localparam int SW = CW + 16;
    localparam int NW = (SW + 1 > TEMPO_W) ? SW + 1 : TEMPO_W;
    localparam int DW = (CW > LAG_W) ? CW : LAG_W;
    localparam int XW = DW + 1;

    // sequencer states
    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_FLUSH     = 4'd1;
    localparam logic [3:0] S_CHECK     = 4'd2;
    localparam logic [3:0] S_DIV_HI    = 4'd3;
    localparam logic [3:0] S_DIV_LO    = 4'd4;
    localparam logic [3:0] S_DIV_MEAN  = 4'd5;
    localparam logic [3:0] S_ISSUE     = 4'd6;
    localparam logic [3:0] S_DRAIN     = 4'd7;
    localparam logic [3:0] S_CORR_END  = 4'd8;
    localparam logic [3:0] S_DIV_TEMPO = 4'd9;
    localparam logic [3:0] S_FINISH    = 4'd10;

    logic [3:0]            state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [BPM_W-1:0]      min_bpm_reg;
    logic [BPM_W-1:0]      max_bpm_reg;
    logic [LAG_W-1:0]      hi_lag_reg;
    logic [LAG_W-1:0]      lag_reg;
    logic [LAG_W-1:0]      best_lag_reg;
    logic [VAL_W-1:0]      mean_reg;
    logic [CW-1:0]         i_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic signed [DIFF_W-1:0] da_reg;
    logic signed [DIFF_W-1:0] db_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  best_reg;
    logic [TEMPO_W-1:0]    tempo_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  m_valid_reg;
    logic [TEMPO_W-1:0]    m_tempo_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic                  s_accept;
    logic                  clr;
    logic                  busy;
    logic [FRAME_W-1:0]    frames;
    logic [CW-1:0]         count;
    logic [SW-1:0]         sum;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [VAL_W-1:0]      wdata;
    logic                  issue;
    logic [AW-1:0]         raddr_b;
    logic [VAL_W-1:0]      rdata_a;
    logic [VAL_W-1:0]      rdata_b;
    logic                  div_start;
    logic [NW-1:0]         div_num;
    logic [DW-1:0]         div_den;
    logic [NW-1:0]         div_quot;
    logic                  div_done;

    logic                  bad_range;
    logic                  too_short;
    logic                  lag_long;
    logic                  weak_peak;
    logic [XW-1:0]         pair_end;
    logic                  pipe_empty;
    logic [31:0]           step_prod;
    logic [STEP_W-1:0]     step_new;
    logic [19:0]           min_frames;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_LOAD);
    assign clr           = (state_reg == S_FINISH) && !m_valid_reg;

    // step from the written sample rate: divide by 200 via reciprocal
    assign step_prod = 32'(cfg_data[SR_W-1:3] * 32'(STEP_RECIP));
    assign step_new  = (step_prod[STEP_SHIFT +: STEP_W] == '0) ? STEP_W'(1)
                                                             : step_prod[STEP_SHIFT +: STEP_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_RESET;
            min_bpm_reg <= MIN_BPM_RESET;
            max_bpm_reg <= MAX_BPM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_RATE: step_reg    <= step_new;
                REG_MIN_BPM:     min_bpm_reg <= cfg_data[BPM_W-1:0];
                REG_MAX_BPM:     max_bpm_reg <= cfg_data[BPM_W-1:0];
                default:         ;
            endcase
        end
    end

    atc_front #(
        .DEPTH (ENVELOPE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (s_accept),
        .left_sample  (s_axis_tdata[15:0]),
        .right_sample (s_axis_tdata[31:16]),
        .step         (step_reg),
        .clr          (clr),
        .busy         (busy),
        .frames       (frames),
        .count        (count),
        .sum          (sum),
        .we           (we),
        .waddr        (waddr),
        .wdata        (wdata)
    );

    // correlation read pairs: entry i and entry i + lag
    assign pair_end = XW'(i_reg) + XW'(lag_reg);
    assign issue    = (state_reg == S_ISSUE) && (pair_end < XW'(count));
    assign raddr_b  = pair_end[AW-1:0];

    atc_store #(
        .DEPTH (ENVELOPE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (issue),
        .raddr_a (i_reg[AW-1:0]),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    atc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    // checks on the finished clip
    assign min_frames = 20'(step_reg * 20'(MIN_FRAMES_PER_STEP));
    assign bad_range  = (min_bpm_reg == '0) || (max_bpm_reg <= min_bpm_reg);
    assign too_short  = (frames < FRAME_W'(min_frames)) || (count < CW'(MIN_POINTS));
    assign lag_long   = XW'(div_quot[LAG_W-1:0]) >= XW'(count);
    assign weak_peak  = (best_reg <= 0) || (best_lag_reg == '0);
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    // divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_num   = NW'(BPM_SCALE);
        div_den   = DW'(min_bpm_reg);
        case (state_reg)
            S_CHECK:
            begin
                div_start = !bad_range && !too_short;
            end
            S_DIV_HI:
            begin
                div_start = div_done && !lag_long;
                div_den   = DW'(max_bpm_reg);
            end
            S_DIV_LO:
            begin
                div_start = div_done;
                div_num   = NW'(sum) + NW'(count >> 1);
                div_den   = DW'(count);
            end
            S_CORR_END:
            begin
                div_start = !weak_peak;
                div_num   = NW'(TEMPO_NUM) + NW'(best_lag_reg >> 1);
                div_den   = DW'(best_lag_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // correlation pipeline: read, center, multiply, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        da_reg   <= $signed({1'b0, rdata_a}) - $signed({1'b0, mean_reg});
        db_reg   <= $signed({1'b0, rdata_b}) - $signed({1'b0, mean_reg});
        prod_reg <= da_reg * db_reg;
    end

    // analysis sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            hi_lag_reg   <= '0;
            lag_reg      <= '0;
            best_lag_reg <= '0;
            mean_reg     <= '0;
            i_reg        <= '0;
            acc_reg      <= '0;
            best_reg     <= -64'sd1;
            tempo_reg    <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            if (v3_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (s_accept && s_axis_tlast)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    if (!busy)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    tempo_reg <= '0;
                    if (bad_range)
                    begin
                        status_reg <= ST_BAD_RANGE;
                        state_reg  <= S_FINISH;
                    end
                    else if (too_short)
                    begin
                        status_reg <= ST_SHORT;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DIV_HI;
                    end
                end
                S_DIV_HI:
                begin
                    if (div_done)
                    begin
                        hi_lag_reg <= div_quot[LAG_W-1:0];
                        if (lag_long)
                        begin
                            status_reg <= ST_LONG_LAG;
                            state_reg  <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_DIV_LO;
                        end
                    end
                end
                S_DIV_LO:
                begin
                    if (div_done)
                    begin
                        lag_reg      <= div_quot[LAG_W-1:0];
                        best_lag_reg <= div_quot[LAG_W-1:0];
                        state_reg    <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot[VAL_W-1:0];
                        best_reg  <= -64'sd1;
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    if (issue)
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (pipe_empty)
                    begin
                        if (acc_reg > best_reg)
                        begin
                            best_reg     <= acc_reg;
                            best_lag_reg <= lag_reg;
                        end
                        acc_reg <= '0;
                        i_reg   <= '0;
                        if (lag_reg == hi_lag_reg)
                        begin
                            state_reg <= S_CORR_END;
                        end
                        else
                        begin
                            lag_reg   <= lag_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_CORR_END:
                begin
                    if (weak_peak)
                    begin
                        status_reg <= ST_WEAK_PEAK;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DIV_TEMPO;
                    end
                end
                S_DIV_TEMPO:
                begin
                    if (div_done)
                    begin
                        tempo_reg  <= div_quot[TEMPO_W-1:0];
                        status_reg <= ST_OK;
                        state_reg  <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!m_valid_reg)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (clr)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            m_tempo_reg  <= tempo_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_status_reg, m_tempo_reg};

endmodule
